// File: rtl/mouse_report_to_quadrature_macros.svh
// Assertion macros used by the mouse report to quadrature top level.
`ifndef MOUSE_REPORT_TO_QUADRATURE_MACROS_SVH
`define MOUSE_REPORT_TO_QUADRATURE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define MRQ_ASSERT_SAME(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("mouse_report_to_quadrature: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define MRQ_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("mouse_report_to_quadrature: next-cycle check failed");

`endif

// File: rtl/mrq_pkg.sv
// Types, codes and helper functions for the mouse report to quadrature block.
`timescale 1ns / 1ps
`default_nettype none

package mrq_pkg;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_LENGTH = 2'd1,
    STATUS_BUSY       = 2'd2
  } status_t;

  localparam logic ACTION_REPORT = 1'b0;
  localparam logic ACTION_TICK   = 1'b1;

  localparam logic [7:0]  REPORT_BYTES      = 8'd8;
  localparam logic [15:0] STEP_INTERVAL_RST = 16'd150;

  typedef struct packed {
    logic       action;
    logic [7:0] report_length;
    logic [7:0] button_byte;
    logic [7:0] x_low_byte;
    logic [7:0] x_direction_byte;
    logic [7:0] y_low_byte;
    logic [7:0] y_direction_byte;
  } item_t;

  typedef struct packed {
    logic    x_a_drive;
    logic    x_b_drive;
    logic    y_a_drive;
    logic    y_b_drive;
    logic    left_drive;
    logic    right_drive;
    status_t status;
    logic    moving;
  } result_t;

  // One Gray step: forward runs 0,1,3,2 and backward runs the reverse.
  function automatic logic [1:0] step_phase(input logic [1:0] phase, input logic forward);
    logic [1:0] nxt;
    unique case (phase)
      2'd0: nxt = forward ? 2'd1 : 2'd2;
      2'd1: nxt = forward ? 2'd3 : 2'd0;
      2'd3: nxt = forward ? 2'd2 : 2'd1;
      2'd2: nxt = forward ? 2'd0 : 2'd3;
      default: nxt = phase;
    endcase
    return nxt;
  endfunction

  // A zero direction byte means the low byte is a negative two's complement count.
  function automatic logic [7:0] load_count(input logic [7:0] low, input logic [7:0] dir);
    return (dir != 8'd0) ? low : (8'd0 - low);
  endfunction

endpackage

`default_nettype wire

// File: rtl/mrq_in_reg.sv
// Input register stage that holds one accepted word until the core takes it.
`timescale 1ns / 1ps
`default_nettype none

module mrq_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mrq_pkg::item_t in_item,
  input  wire logic          advance,
  output logic               item_valid,
  output mrq_pkg::item_t     item
);

  logic accept;
  logic fire;

  assign in_stall = item_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign fire     = item_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mrq_core.sv
// Step engine: button and count state, wait counter and the per-word update.
`timescale 1ns / 1ps
`default_nettype none

module mrq_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [15:0]    cfg_data,
  input  wire logic           fire,
  input  wire mrq_pkg::item_t item,
  output mrq_pkg::result_t    result
);

  logic [15:0] step_interval;
  logic [1:0]  horiz_phase, horiz_phase_next;
  logic [1:0]  vert_phase, vert_phase_next;
  logic [7:0]  horiz_pending, horiz_pending_next;
  logic [7:0]  vert_pending, vert_pending_next;
  logic        horiz_forward, horiz_forward_next;
  logic        vert_forward, vert_forward_next;
  logic [1:0]  button_drives, button_drives_next;
  logic [15:0] wait_count, wait_count_next;
  logic [15:0] wait_after_step;
  logic        busy;
  mrq_pkg::status_t status;

  // An interval of zero behaves like one: no wait between steps.
  assign wait_after_step = (step_interval == 16'd0) ? 16'd0 : step_interval - 16'd1;
  assign busy = (horiz_pending != 8'd0) || (vert_pending != 8'd0) || (wait_count != 16'd0);

  always_comb begin
    horiz_phase_next   = horiz_phase;
    vert_phase_next    = vert_phase;
    horiz_pending_next = horiz_pending;
    vert_pending_next  = vert_pending;
    horiz_forward_next = horiz_forward;
    vert_forward_next  = vert_forward;
    button_drives_next = button_drives;
    wait_count_next    = wait_count;
    status             = mrq_pkg::STATUS_OK;

    if (item.action == mrq_pkg::ACTION_TICK) begin
      if (wait_count != 16'd0) begin
        wait_count_next = wait_count - 16'd1;
      end else if (horiz_pending != 8'd0) begin
        horiz_phase_next   = mrq_pkg::step_phase(horiz_phase, horiz_forward);
        horiz_pending_next = horiz_pending - 8'd1;
        wait_count_next    = wait_after_step;
      end else if (vert_pending != 8'd0) begin
        vert_phase_next   = mrq_pkg::step_phase(vert_phase, vert_forward);
        vert_pending_next = vert_pending - 8'd1;
        wait_count_next   = wait_after_step;
      end
    end else if (busy) begin
      status = mrq_pkg::STATUS_BUSY;
    end else if (item.report_length != mrq_pkg::REPORT_BYTES) begin
      status = mrq_pkg::STATUS_BAD_LENGTH;
    end else begin
      button_drives_next = item.button_byte[1:0];
      horiz_forward_next = (item.x_direction_byte != 8'd0);
      horiz_pending_next = mrq_pkg::load_count(item.x_low_byte, item.x_direction_byte);
      vert_forward_next  = (item.y_direction_byte != 8'd0);
      vert_pending_next  = mrq_pkg::load_count(item.y_low_byte, item.y_direction_byte);
    end

    result.x_a_drive   = horiz_phase_next[0];
    result.x_b_drive   = horiz_phase_next[1];
    result.y_a_drive   = vert_phase_next[0];
    result.y_b_drive   = vert_phase_next[1];
    result.left_drive  = button_drives_next[0];
    result.right_drive = button_drives_next[1];
    result.status      = status;
    result.moving      = (horiz_pending_next != 8'd0) || (vert_pending_next != 8'd0) ||
                         (wait_count_next != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= mrq_pkg::STEP_INTERVAL_RST;
    end else if (cfg_we) begin
      step_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      horiz_phase   <= 2'd0;
      vert_phase    <= 2'd0;
      horiz_pending <= 8'd0;
      vert_pending  <= 8'd0;
      horiz_forward <= 1'b0;
      vert_forward  <= 1'b0;
      button_drives <= 2'd0;
      wait_count    <= 16'd0;
    end else if (fire) begin
      horiz_phase   <= horiz_phase_next;
      vert_phase    <= vert_phase_next;
      horiz_pending <= horiz_pending_next;
      vert_pending  <= vert_pending_next;
      horiz_forward <= horiz_forward_next;
      vert_forward  <= vert_forward_next;
      button_drives <= button_drives_next;
      wait_count    <= wait_count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mrq_out_reg.sv
// Result register that holds one finished word until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module mrq_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire mrq_pkg::result_t result_in,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output mrq_pkg::result_t      result_out
);

  // The register can take a new result when empty or when its word leaves now.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mouse_report_to_quadrature.sv
// Top level: HID mouse reports and time ticks in, quadrature and button line drives out.
//
// Input channel: in_valid / in_stall carry one word per accepted edge. A word is either
// a mouse report (action 0, with length, button and movement bytes) or one time tick
// (action 1). The output channel out_valid / out_stall returns exactly one result word
// for every input word: the four quadrature line drives, the two button drives, a status
// code (accepted or tick, bad length, busy) and the moving flag.
// The step interval register is written through cfg_we / cfg_data while the block is
// idle, a rule the user must keep that the block itself does not enforce; the interval
// counts ticks from one quadrature step to the next. An accepted word sits in the input
// register until the result register can take its result; the state update then runs
// in a single pass and lands in the result register, which raises out_valid.
// One word is accepted every cycle as long as the receiver keeps up.
// When the receiver stalls, the waiting result holds in the result register and one
// more word can still be taken into the input register; in_stall rises only when both
// are full. Synchronous reset empties both registers, clears the pending steps and the
// wait count, and sets the step interval back to 150 ticks.
`timescale 1ns / 1ps
`default_nettype none

`include "mouse_report_to_quadrature_macros.svh"

module mouse_report_to_quadrature (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [7:0]  report_length,
  input  wire logic [7:0]  button_byte,
  input  wire logic [7:0]  x_low_byte,
  input  wire logic [7:0]  x_direction_byte,
  input  wire logic [7:0]  y_low_byte,
  input  wire logic [7:0]  y_direction_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             x_a_drive,
  output logic             x_b_drive,
  output logic             y_a_drive,
  output logic             y_b_drive,
  output logic             left_drive,
  output logic             right_drive,
  output logic [1:0]       status,
  output logic             moving
);

  mrq_pkg::item_t   in_item;
  mrq_pkg::item_t   item;
  mrq_pkg::result_t result_core;
  mrq_pkg::result_t result_q;
  logic             item_valid;
  logic             advance;
  logic             fire;

  assign in_item.action           = action;
  assign in_item.report_length    = report_length;
  assign in_item.button_byte      = button_byte;
  assign in_item.x_low_byte       = x_low_byte;
  assign in_item.x_direction_byte = x_direction_byte;
  assign in_item.y_low_byte       = y_low_byte;
  assign in_item.y_direction_byte = y_direction_byte;

  // The held word is processed whenever the result register can take its result.
  assign fire = item_valid && advance;

  mrq_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mrq_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fire     (fire),
    .item     (item),
    .result   (result_core)
  );

  mrq_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .result_in  (result_core),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (result_q)
  );

  assign x_a_drive   = result_q.x_a_drive;
  assign x_b_drive   = result_q.x_b_drive;
  assign y_a_drive   = result_q.y_a_drive;
  assign y_b_drive   = result_q.y_b_drive;
  assign left_drive  = result_q.left_drive;
  assign right_drive = result_q.right_drive;
  assign status      = result_q.status;
  assign moving      = result_q.moving;

  // A refused busy report leaves the state untouched, so motion is still pending.
  `MRQ_ASSERT_SAME(a_busy_means_moving, out_valid && (status == mrq_pkg::STATUS_BUSY), moving)
  // A bad length is only reported when the block was idle, and it stays idle.
  `MRQ_ASSERT_SAME(a_bad_len_idle, out_valid && (status == mrq_pkg::STATUS_BAD_LENGTH), !moving)
  // The input side only stalls while a word is already held.
  `MRQ_ASSERT_SAME(a_stall_only_when_full, in_stall, item_valid)
  // A processed word always shows up in the result register next cycle.
  `MRQ_ASSERT_NEXT(a_fire_gives_result, fire, out_valid)

endmodule

`default_nettype wire

// File: tb/mouse_report_to_quadrature_checker.sv
// Checker for the mouse report to quadrature block: predicts each result word and compares it.
`timescale 1ns / 1ps

module mouse_report_to_quadrature_checker
  import mrq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [7:0]  report_length,
  input  logic [7:0]  button_byte,
  input  logic [7:0]  x_low_byte,
  input  logic [7:0]  x_direction_byte,
  input  logic [7:0]  y_low_byte,
  input  logic [7:0]  y_direction_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        x_a_drive,
  input  logic        x_b_drive,
  input  logic        y_a_drive,
  input  logic        y_b_drive,
  input  logic        left_drive,
  input  logic        right_drive,
  input  logic [1:0]  status,
  input  logic        moving,
  output int          mismatch_count,
  output int          expected_count
);

  // Shadow of the block's register and movement state.
  logic [15:0] interval_reg;
  logic [1:0]  x_phase;
  logic [1:0]  y_phase;
  logic [7:0]  x_steps;
  logic [7:0]  y_steps;
  logic        x_fwd;
  logic        y_fwd;
  logic [1:0]  buttons;
  logic [15:0] wait_ticks;
  result_t     line_drives_q[$];
  int          result_index;

  // Gray phase to position on the 0,1,3,2 ring, move one place, and back.
  function automatic logic [1:0] next_gray(input logic [1:0] g, input logic fwd);
    logic [1:0] pos;
    pos = {g[1], g[1] ^ g[0]};
    pos = fwd ? pos + 2'd1 : pos - 2'd1;
    return {pos[1], pos[1] ^ pos[0]};
  endfunction

  function automatic logic [7:0] axis_count(input logic [7:0] low, input logic [7:0] dir);
    logic [8:0] neg;
    neg = 9'd256 - {1'b0, low};
    return (dir != 8'd0) ? low : neg[7:0];
  endfunction

  task automatic predict_line_drives(input item_t w, output result_t r);
    status_t     st;
    logic [15:0] reload;
    st = STATUS_OK;
    reload = (interval_reg == 16'd0) ? 16'd0 : interval_reg - 16'd1;
    if (w.action == ACTION_TICK) begin
      if (wait_ticks != 16'd0) begin
        wait_ticks = wait_ticks - 16'd1;
      end else if (x_steps != 8'd0) begin
        x_phase = next_gray(x_phase, x_fwd);
        x_steps = x_steps - 8'd1;
        wait_ticks = reload;
      end else if (y_steps != 8'd0) begin
        y_phase = next_gray(y_phase, y_fwd);
        y_steps = y_steps - 8'd1;
        wait_ticks = reload;
      end
    end else if (x_steps != 8'd0 || y_steps != 8'd0 || wait_ticks != 16'd0) begin
      st = STATUS_BUSY;
    end else if (w.report_length != REPORT_BYTES) begin
      st = STATUS_BAD_LENGTH;
    end else begin
      buttons = w.button_byte[1:0];
      x_fwd = (w.x_direction_byte != 8'd0);
      x_steps = axis_count(w.x_low_byte, w.x_direction_byte);
      y_fwd = (w.y_direction_byte != 8'd0);
      y_steps = axis_count(w.y_low_byte, w.y_direction_byte);
    end
    r.x_a_drive = x_phase[0];
    r.x_b_drive = x_phase[1];
    r.y_a_drive = y_phase[0];
    r.y_b_drive = y_phase[1];
    r.left_drive = buttons[0];
    r.right_drive = buttons[1];
    r.status = st;
    r.moving = (x_steps != 8'd0) || (y_steps != 8'd0) || (wait_ticks != 16'd0);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result word %0d: %s", $time, result_index, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [1:0] seen, input logic [1:0] wanted);
    if (seen !== wanted)
      report_mismatch($sformatf("%s is %0d, predicted %0d", name, seen, wanted));
  endtask

  always @(posedge clk) begin : watch
    item_t   w;
    result_t want;
    if (rst) begin
      interval_reg = STEP_INTERVAL_RST;
      x_phase = 2'd0;
      y_phase = 2'd0;
      x_steps = 8'd0;
      y_steps = 8'd0;
      x_fwd = 1'b0;
      y_fwd = 1'b0;
      buttons = 2'd0;
      wait_ticks = 16'd0;
      line_drives_q.delete();
      result_index = 0;
      mismatch_count = 0;
    end else begin
      if (cfg_we)
        interval_reg = cfg_data;
      if (out_valid && !out_stall) begin
        if (line_drives_q.size() == 0) begin
          report_mismatch("arrived with no prediction waiting");
        end else begin
          want = line_drives_q.pop_front();
          check_field("x_a_drive", x_a_drive, want.x_a_drive);
          check_field("x_b_drive", x_b_drive, want.x_b_drive);
          check_field("y_a_drive", y_a_drive, want.y_a_drive);
          check_field("y_b_drive", y_b_drive, want.y_b_drive);
          check_field("left_drive", left_drive, want.left_drive);
          check_field("right_drive", right_drive, want.right_drive);
          check_field("status", status, want.status);
          check_field("moving", moving, want.moving);
        end
        result_index++;
      end
      if (in_valid && !in_stall) begin
        w.action = action;
        w.report_length = report_length;
        w.button_byte = button_byte;
        w.x_low_byte = x_low_byte;
        w.x_direction_byte = x_direction_byte;
        w.y_low_byte = y_low_byte;
        w.y_direction_byte = y_direction_byte;
        predict_line_drives(w, want);
        line_drives_q.push_back(want);
      end
    end
    expected_count <= line_drives_q.size();
  end

endmodule

// File: tb/mouse_report_to_quadrature_tb.sv
// Testbench top for the mouse report to quadrature block: stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module mouse_report_to_quadrature_tb;
  import mrq_pkg::*;

  // No accepted word on either side for this many cycles means the block hung.
  // The longest legal gap is a long receiver hold plus a sender burst, far below this.
  localparam int STALL_LIMIT      = 2000;
  localparam int LONG_HOLD_CYCLES = 48;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        action = 1'b0;
  logic [7:0]  report_length = 8'd0;
  logic [7:0]  button_byte = 8'd0;
  logic [7:0]  x_low_byte = 8'd0;
  logic [7:0]  x_direction_byte = 8'd0;
  logic [7:0]  y_low_byte = 8'd0;
  logic [7:0]  y_direction_byte = 8'd0;
  logic        out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        x_a_drive;
  logic        x_b_drive;
  logic        y_a_drive;
  logic        y_b_drive;
  logic        left_drive;
  logic        right_drive;
  logic [1:0]  status;
  logic        moving;

  int          mismatch_count;
  int          expected_count;
  int          quiet_cycles = 0;

  // Knobs shared between the stimulus and the receiver process.
  bit          sender_quiet = 1'b0;
  bit          receiver_quiet = 1'b0;
  bit          hold_request = 1'b0;
  // Moving flag of the most recent result word; it steers the sender toward
  // reports when the block has gone idle and toward ticks while it moves.
  logic        last_moving = 1'b0;

  always #6 clk = ~clk;

  mouse_report_to_quadrature u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .report_length    (report_length),
    .button_byte      (button_byte),
    .x_low_byte       (x_low_byte),
    .x_direction_byte (x_direction_byte),
    .y_low_byte       (y_low_byte),
    .y_direction_byte (y_direction_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .x_a_drive        (x_a_drive),
    .x_b_drive        (x_b_drive),
    .y_a_drive        (y_a_drive),
    .y_b_drive        (y_b_drive),
    .left_drive       (left_drive),
    .right_drive      (right_drive),
    .status           (status),
    .moving           (moving)
  );

  mouse_report_to_quadrature_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .report_length    (report_length),
    .button_byte      (button_byte),
    .x_low_byte       (x_low_byte),
    .x_direction_byte (x_direction_byte),
    .y_low_byte       (y_low_byte),
    .y_direction_byte (y_direction_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .x_a_drive        (x_a_drive),
    .x_b_drive        (x_b_drive),
    .y_a_drive        (y_a_drive),
    .y_b_drive        (y_b_drive),
    .left_drive       (left_drive),
    .right_drive      (right_drive),
    .status           (status),
    .moving           (moving),
    .mismatch_count   (mismatch_count),
    .expected_count   (expected_count)
  );

  // Watchdog: any accepted word on either channel restarts the count. The same
  // process records the moving flag of each accepted result word.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (out_valid && !out_stall)
      last_moving <= moving;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver. It stalls in random bursts, and once on request
  // it holds off for a long stretch that it counts itself, so that both of the
  // block's registers fill and in_stall rises while the sender keeps offering.
  initial begin : receiver
    int burst;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        hold_request <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!receiver_quiet && !rst && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // A tick carries random bytes in the report fields; the block must ignore them,
  // and they help every payload bit see both values.
  function automatic item_t tick_word();
    item_t w;
    w.action = ACTION_TICK;
    w.report_length = 8'($urandom);
    w.button_byte = 8'($urandom);
    w.x_low_byte = 8'($urandom);
    w.x_direction_byte = 8'($urandom);
    w.y_low_byte = 8'($urandom);
    w.y_direction_byte = 8'($urandom);
    return w;
  endfunction

  function automatic item_t make_report(input logic [7:0] len, input logic [7:0] btn,
                                        input logic [7:0] xl, input logic [7:0] xd,
                                        input logic [7:0] yl, input logic [7:0] yd);
    item_t w;
    w.action = ACTION_REPORT;
    w.report_length = len;
    w.button_byte = btn;
    w.x_low_byte = xl;
    w.x_direction_byte = xd;
    w.y_low_byte = yl;
    w.y_direction_byte = yd;
    return w;
  endfunction

  // Low and direction bytes for a chosen step count: a nonzero direction byte takes
  // the count as is, a zero one takes its two's complement.
  function automatic logic [15:0] axis_bytes(input int steps);
    logic [7:0] dir;
    dir = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 255)) : 8'd0;
    return {(dir != 8'd0) ? 8'(steps) : 8'(0 - steps), dir};
  endfunction

  // Mostly well-formed reports with small step counts so that motion finishes in a
  // reasonable number of ticks; some have a wrong length or fully random bytes.
  function automatic item_t report_word(input int max_steps, input int scramble_pct);
    item_t w;
    w = make_report(REPORT_BYTES, 8'($urandom), 8'd0, 8'd0, 8'd0, 8'd0);
    if ($urandom_range(0, 7) == 0)
      w.report_length = 8'($urandom);
    if ($urandom_range(0, 99) < scramble_pct) begin
      w.x_low_byte = 8'($urandom);
      w.x_direction_byte = 8'($urandom);
      w.y_low_byte = 8'($urandom);
      w.y_direction_byte = 8'($urandom);
    end else begin
      {w.x_low_byte, w.x_direction_byte} = axis_bytes($urandom_range(0, max_steps));
      {w.y_low_byte, w.y_direction_byte} = axis_bytes($urandom_range(0, max_steps));
    end
    return w;
  endfunction

  // Offers one word and returns at the edge where it is accepted. A random idle
  // burst may come first; back-to-back words keep in_valid high throughout.
  task automatic send_word(input item_t w);
    int gap;
    if (!sender_quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {action, report_length, button_byte, x_low_byte, x_direction_byte,
     y_low_byte, y_direction_byte} <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The sender goes quiet until every predicted result word has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_count != 0);
  endtask

  task automatic write_interval(input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_data <= 16'($urandom);
  endtask

  // Ticks in batches until the last result word says the block has stopped moving,
  // so the next phase starts from an idle mover.
  task automatic run_out_motion();
    wait_for_drain();
    while (last_moving) begin
      repeat (32) send_word(tick_word());
      wait_for_drain();
    end
  endtask

  // A random phase. Reports dominate while the block is idle and ticks while it
  // moves, so most reports are accepted and then played out to the end.
  task automatic run_phase(input int words, input int max_steps, input int scramble_pct);
    item_t w;
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 99) < (last_moving ? 8 : 60))
        w = report_word(max_steps, scramble_pct);
      else
        w = tick_word();
      send_word(w);
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset interval of 150 ticks.
    send_word(tick_word());                                             // tick, nothing pending
    send_word(make_report(8'd0, 8'hFF, 8'h01, 8'h01, 8'h01, 8'h01));    // too short
    send_word(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));   // too long
    // Zero counts on both axes, X with a forward and Y with a backward
    // direction byte: accepted, buttons pressed, nothing to move.
    send_word(make_report(REPORT_BYTES, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00));
    // One step to the left; buttons released.
    send_word(make_report(REPORT_BYTES, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h80));
    // Refused as busy before any tick: an accepted report only loads its counts.
    send_word(make_report(REPORT_BYTES, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
    send_word(tick_word());                                             // first X step
    // Busy takes precedence over a bad length.
    send_word(make_report(8'd9, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(tick_word());

    // Reset interval: motion is slow, so counts stay at one step per axis.
    run_phase(160, 1, 0);
    run_out_motion();

    // Zero interval acts as one: steps on consecutive ticks. The receiver holds off
    // at the start of this phase while words keep coming.
    write_interval(16'd0);
    hold_request <= 1'b1;
    send_word(make_report(REPORT_BYTES, 8'h02, 8'h01, 8'h00, 8'h03, 8'h01));
    repeat (24) send_word(tick_word());
    run_out_motion();
    // Largest count on X (255 to the left), a couple of steps down on Y.
    send_word(make_report(REPORT_BYTES, 8'h03, 8'h01, 8'h00, 8'h02, 8'h01));
    run_phase(120, 6, 10);
    run_out_motion();

    write_interval(16'd1);
    run_phase(120, 5, 5);
    run_out_motion();

    write_interval(16'd3);
    run_phase(100, 3, 0);
    run_out_motion();

    write_interval(16'($urandom_range(2, 6)));
    run_phase(100, 4, 0);
    run_out_motion();

    // Largest interval, with no idling on either side. A report is taken, its first
    // step lands, and the long wait is still counting down when the run ends.
    write_interval(16'hFFFF);
    sender_quiet = 1'b1;
    receiver_quiet <= 1'b1;
    send_word(make_report(REPORT_BYTES, 8'($urandom), 8'h02, 8'h01, 8'h00, 8'h01));
    run_phase(60, 2, 30);

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
